// ----- rtl/core/tts_pkg.sv -----
// Package for the text terminal screen engine.
// Screen geometry, command codes and the controller/datapath interface types.
// No dependencies.
package tts_pkg;

   localparam int ROWS   = 24;
   localparam int COLS   = 80;
   localparam int CELLS  = ROWS * COLS;
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLS);
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);

   localparam logic [7:0] BLANK = 8'h20;

   localparam logic [4:0] OP_GLYPH     = 5'd0;
   localparam logic [4:0] OP_LF        = 5'd1;
   localparam logic [4:0] OP_CR        = 5'd2;
   localparam logic [4:0] OP_BS        = 5'd3;
   localparam logic [4:0] OP_TAB       = 5'd4;
   localparam logic [4:0] OP_UP        = 5'd5;
   localparam logic [4:0] OP_FWD       = 5'd6;
   localparam logic [4:0] OP_HOME      = 5'd7;
   localparam logic [4:0] OP_CLR_HOME  = 5'd8;
   localparam logic [4:0] OP_EL_END    = 5'd9;
   localparam logic [4:0] OP_ES_END    = 5'd10;
   localparam logic [4:0] OP_EL_START  = 5'd11;
   localparam logic [4:0] OP_EL_ALL    = 5'd12;
   localparam logic [4:0] OP_ES_START  = 5'd13;
   localparam logic [4:0] OP_ES_ALL    = 5'd14;
   localparam logic [4:0] OP_PLACE     = 5'd15;
   localparam logic [4:0] OP_READ      = 5'd16;
   localparam logic [4:0] OP_ACK       = 5'd17;

   typedef enum logic [1:0] {
      ACT_DONE   = 2'd0,
      ACT_SWEEP  = 2'd1,
      ACT_SCROLL = 2'd2,
      ACT_READ   = 2'd3
   } act_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic sweep;
      logic scr_rd;
      logic scr_wr;
      logic read_cap;
      logic finish;
   } cmd_type;

   typedef struct packed {
      act_type act;
      logic    sweep_last;
      logic    scroll_last;
      logic    rsp_free;
   } stat_type;

endpackage

// ----- rtl/core/text_terminal_screen_engine.sv -----
// Top level of the text terminal screen engine.
// Instantiates tts_ctrl and tts_datapath; depends on tts_pkg.
//
// A 24 x 80 character-cell screen (glyph and attribute per cell) with a
// cursor and a dirty flag. Each req_ transaction carries one terminal
// command and yields exactly one rsp_ transaction with the read character
// (read command only, else 0), the cursor after the command and the dirty
// flag. Commands run one at a time through a cell memory pair with one
// write and one read port. Erases blank one cell per cycle; a scroll (line
// feed or wrap on the bottom row) copies each cell with a read step and a
// write step and then blanks the bottom line. After reset the block blanks
// all 1920 cells, one per cycle, with req_ready low. A finished result
// waits in the output register, and the next command is taken while it
// waits.
module text_terminal_screen_engine
   import tts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [4:0]        req_op,
   input  logic [7:0]        req_glyph,
   input  logic [7:0]        req_attribute,
   input  logic signed [9:0] req_row,
   input  logic signed [9:0] req_column,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [6:0]        rsp_read_char,
   output logic [4:0]        rsp_cursor_row,
   output logic [6:0]        rsp_cursor_col,
   output logic              rsp_dirty
);

   cmd_type  cmd;
   stat_type stat;

   // sequencing: init sweep, execute, erase sweep, scroll copy, read capture, respond
   tts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // memories, cursor and result register
   tts_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_op         (req_op),
      .req_glyph      (req_glyph),
      .req_attribute  (req_attribute),
      .req_row        (req_row),
      .req_column     (req_column),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_char  (rsp_read_char),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_dirty      (rsp_dirty)
   );

endmodule

// ----- rtl/core/tts_ctrl.sv -----
// Controller state machine of the text terminal screen engine.
// Depends on tts_pkg; drives tts_datapath through cmd_type / stat_type.
module tts_ctrl
   import tts_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [7:0] {
      ST_INIT   = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_EXEC   = 8'b0000_0100,
      ST_SWEEP  = 8'b0000_1000,
      ST_SCR_RD = 8'b0001_0000,
      ST_SCR_WR = 8'b0010_0000,
      ST_READ   = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            unique case (stat.act)
               ACT_DONE:   state_in = ST_DONE;
               ACT_SWEEP:  state_in = ST_SWEEP;
               ACT_SCROLL: state_in = ST_SCR_RD;
               ACT_READ:   state_in = ST_READ;
               default:    state_in = ST_DONE;
            endcase
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) state_in = ST_DONE;
         end
         ST_SCR_RD: begin
            cmd.scr_rd = 1'b1;
            state_in   = ST_SCR_WR;
         end
         ST_SCR_WR: begin
            cmd.scr_wr = 1'b1;
            state_in   = stat.scroll_last ? ST_SWEEP : ST_SCR_RD;
         end
         ST_READ: begin
            cmd.read_cap = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_INIT;
      else       state_ff <= state_in;
   end

endmodule

// ----- rtl/core/tts_datapath.sv -----
// Datapath of the text terminal screen engine: cell memories, cursor,
// dirty flag, sweep pointer and result register. Depends on tts_pkg.
module tts_datapath
   import tts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic [4:0]        req_op,
   input  logic [7:0]        req_glyph,
   input  logic [7:0]        req_attribute,
   input  logic signed [9:0] req_row,
   input  logic signed [9:0] req_column,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [6:0]        rsp_read_char,
   output logic [4:0]        rsp_cursor_row,
   output logic [6:0]        rsp_cursor_col,
   output logic              rsp_dirty
);

   logic [7:0] glyph_mem [CELLS];
   logic [7:0] attr_mem  [CELLS];

   logic [4:0]        op_ff;
   logic [7:0]        glyph_ff, attr_ff;
   logic signed [9:0] row_ff, col_ff;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic              dirty_ff, dirty_in;
   logic [CNT_W-1:0]  ptr_ff, end_ff;
   logic [7:0]        rd_glyph_ff, rd_attr_ff;
   logic [6:0]        char_ff, char_in;
   logic              rsp_valid_ff;
   logic [6:0]        rsp_char_ff, rsp_col_ff;
   logic [4:0]        rsp_row_ff;
   logic              rsp_dirty_ff;

   // exec decode
   logic [CNT_W-1:0]  line, pos, sw_start, sw_end, rd_addr;
   logic [COL_W:0]    col_p1, tab_n;
   logic              wrap, row_last, in_rng;
   act_type           act;

   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [7:0]        mem_wg, mem_wa;

   always_comb begin
      line     = CNT_W'(cur_row_ff) * CNT_W'(COLS);
      pos      = line + CNT_W'(cur_col_ff);
      col_p1   = (COL_W+1)'(cur_col_ff) + (COL_W+1)'(1);
      wrap     = col_p1 >= (COL_W+1)'(COLS);
      row_last = cur_row_ff == ROW_W'(ROWS - 1);
      tab_n    = ((COL_W+1)'(cur_col_ff) & ~(COL_W+1)'(7)) + (COL_W+1)'(8);
      in_rng   = !row_ff[9] && (row_ff < 10'(ROWS)) && !col_ff[9] && (col_ff < 10'(COLS));
      rd_addr  = CNT_W'(row_ff[ROW_W-1:0]) * CNT_W'(COLS) + CNT_W'(col_ff[COL_W-1:0]);

      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      dirty_in   = dirty_ff;
      act        = ACT_DONE;
      sw_start   = '0;
      sw_end     = CNT_W'(CELLS);
      char_in    = '0;
      case (op_ff)
         OP_GLYPH, OP_FWD: begin
            dirty_in = 1'b1;
            if (wrap) begin
               cur_col_in = '0;
               if (row_last) act = ACT_SCROLL;
               else          cur_row_in = cur_row_ff + ROW_W'(1);
            end else begin
               cur_col_in = col_p1[COL_W-1:0];
            end
         end
         OP_LF: begin
            dirty_in = 1'b1;
            if (row_last) act = ACT_SCROLL;
            else          cur_row_in = cur_row_ff + ROW_W'(1);
         end
         OP_CR: begin
            cur_col_in = '0;
            dirty_in   = 1'b1;
         end
         OP_BS: begin
            if (cur_col_ff != '0) begin
               cur_col_in = cur_col_ff - COL_W'(1);
               dirty_in   = 1'b1;
            end
         end
         OP_TAB: begin
            if (tab_n < (COL_W+1)'(COLS)) begin
               cur_col_in = tab_n[COL_W-1:0];
               dirty_in   = 1'b1;
            end
         end
         OP_UP: begin
            if (cur_row_ff != '0) begin
               cur_row_in = cur_row_ff - ROW_W'(1);
               dirty_in   = 1'b1;
            end
         end
         OP_HOME: begin
            cur_row_in = '0;
            cur_col_in = '0;
            dirty_in   = 1'b1;
         end
         OP_CLR_HOME: begin
            cur_row_in = '0;
            cur_col_in = '0;
            dirty_in   = 1'b1;
            act        = ACT_SWEEP;
         end
         OP_EL_END: begin
            dirty_in = 1'b1;
            act      = ACT_SWEEP;
            sw_start = pos;
            sw_end   = line + CNT_W'(COLS);
         end
         OP_ES_END: begin
            dirty_in = 1'b1;
            act      = ACT_SWEEP;
            sw_start = pos;
         end
         OP_EL_START: begin
            dirty_in = 1'b1;
            act      = ACT_SWEEP;
            sw_start = line;
            sw_end   = pos + CNT_W'(1);
         end
         OP_EL_ALL: begin
            dirty_in = 1'b1;
            act      = ACT_SWEEP;
            sw_start = line;
            sw_end   = line + CNT_W'(COLS);
         end
         OP_ES_START: begin
            dirty_in = 1'b1;
            act      = ACT_SWEEP;
            sw_end   = pos + CNT_W'(1);
         end
         OP_ES_ALL: begin
            dirty_in = 1'b1;
            act      = ACT_SWEEP;
         end
         OP_PLACE: begin
            dirty_in = 1'b1;
            if (row_ff[9])                 cur_row_in = '0;
            else if (row_ff >= 10'(ROWS))  cur_row_in = ROW_W'(ROWS - 1);
            else                           cur_row_in = row_ff[ROW_W-1:0];
            if (col_ff[9])                 cur_col_in = '0;
            else if (col_ff >= 10'(COLS))  cur_col_in = COL_W'(COLS - 1);
            else                           cur_col_in = col_ff[COL_W-1:0];
         end
         OP_READ: begin
            if (in_rng) act = ACT_READ;
            else        char_in = BLANK[6:0];
         end
         OP_ACK: dirty_in = 1'b0;
         default: ;
      endcase
   end

   // memory port muxing
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = ptr_ff[ADDR_W-1:0];
      mem_wg    = BLANK;
      mem_wa    = '0;
      if (cmd.exec && op_ff == OP_GLYPH) begin
         mem_we    = 1'b1;
         mem_waddr = pos[ADDR_W-1:0];
         mem_wg    = glyph_ff;
         mem_wa    = attr_ff;
      end else if (cmd.sweep) begin
         mem_we = 1'b1;
      end else if (cmd.scr_wr) begin
         mem_we = 1'b1;
         mem_wg = rd_glyph_ff;
         mem_wa = rd_attr_ff;
      end
      mem_re    = cmd.scr_rd || (cmd.exec && act == ACT_READ);
      mem_raddr = cmd.scr_rd ? ADDR_W'(ptr_ff + CNT_W'(COLS))
                             : rd_addr[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         glyph_mem[mem_waddr] <= mem_wg;
         attr_mem[mem_waddr]  <= mem_wa;
      end
      if (mem_re) begin
         rd_glyph_ff <= glyph_mem[mem_raddr];
         rd_attr_ff  <= attr_mem[mem_raddr];
      end
   end

   // captured request and read result
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         glyph_ff <= req_glyph;
         attr_ff  <= req_attribute;
         row_ff   <= req_row;
         col_ff   <= req_column;
      end
      if (cmd.exec)          char_ff <= char_in;
      else if (cmd.read_cap) char_ff <= rd_glyph_ff[6:0];
   end

   // cursor, dirty flag, sweep pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff <= '0;
         cur_col_ff <= '0;
         dirty_ff   <= 1'b0;
         ptr_ff     <= '0;
         end_ff     <= CNT_W'(CELLS);
      end else begin
         if (cmd.exec) begin
            cur_row_ff <= cur_row_in;
            cur_col_ff <= cur_col_in;
            dirty_ff   <= dirty_in;
            ptr_ff     <= (act == ACT_SWEEP) ? sw_start : '0;
            end_ff     <= (act == ACT_SWEEP) ? sw_end : CNT_W'(CELLS);
         end else if (cmd.sweep || cmd.scr_wr) begin
            ptr_ff <= ptr_ff + CNT_W'(1);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset)              rsp_valid_ff <= 1'b0;
      else if (cmd.finish)    rsp_valid_ff <= 1'b1;
      else if (rsp_ready)     rsp_valid_ff <= 1'b0;
      if (cmd.finish) begin
         rsp_char_ff  <= char_ff;
         rsp_row_ff   <= 5'(cur_row_ff);
         rsp_col_ff   <= 7'(cur_col_ff);
         rsp_dirty_ff <= dirty_ff;
      end
   end

   assign stat.act         = act;
   assign stat.sweep_last  = CNT_W'(ptr_ff + CNT_W'(1)) == end_ff;
   assign stat.scroll_last = ptr_ff == CNT_W'(CELLS - COLS - 1);
   assign stat.rsp_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_char  = rsp_char_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_dirty      = rsp_dirty_ff;

endmodule

// ----- rtl/core/tts_checker.sv -----
// Port-level checks for text_terminal_screen_engine, bound to the top level.
// Depends on tts_pkg.
module tts_checker
   import tts_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_read_char,
   input logic [4:0] rsp_cursor_row,
   input logic [6:0] rsp_cursor_col,
   input logic       rsp_dirty
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_char)
         && $stable(rsp_cursor_row) && $stable(rsp_cursor_col) && $stable(rsp_dirty))
      else $error("stalled result changed");

   // reset starts the clearing pass: no command taken, no result
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("activity right after reset");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_cursor_row) < ROWS)
      else $error("cursor row off screen");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_cursor_col) < COLS)
      else $error("cursor column off screen");

endmodule

bind text_terminal_screen_engine tts_checker u_tts_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_read_char  (rsp_read_char),
   .rsp_cursor_row (rsp_cursor_row),
   .rsp_cursor_col (rsp_cursor_col),
   .rsp_dirty      (rsp_dirty)
);
